FILE: design/polar_decomposition_3x3_core_assert.svh
// Assertion macros used by the checker file.
`ifndef POLAR_DECOMPOSITION_3X3_CORE_ASSERT_SVH
`define POLAR_DECOMPOSITION_3X3_CORE_ASSERT_SVH

// Clocked property, disabled while the active-low reset is asserted.
`define PD_ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("pd assertion failed");

// Same, but also checked during reset.
`define PD_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("pd assertion failed");

`endif

FILE: design/pd_pkg.sv
// ----------------------------------------------------------------------------
// pd_pkg
// Types, constants and rounding helpers for the polar decomposition core.
// ----------------------------------------------------------------------------
`default_nettype none
package pd_pkg;

    localparam int FRAC_BITS_DEF = 28;
    localparam int ACC_W         = 68;
    localparam int QUO_W         = 32;

    localparam logic [3:0]  MAX_IT_RST = 4'd10;
    localparam logic [30:0] TOL_RST    = 31'd268;

    localparam logic CFG_MAX_IT = 1'b0;
    localparam logic CFG_TOL    = 1'b1;

    typedef enum logic [1:0] {
        MAC_HOLD,
        MAC_LOAD,
        MAC_ADD,
        MAC_SUB
    } t_mac_op;

    typedef struct packed {
        logic signed [31:0] m00;
        logic signed [31:0] m01;
        logic signed [31:0] m02;
        logic signed [31:0] m10;
        logic signed [31:0] m11;
        logic signed [31:0] m12;
        logic signed [31:0] m20;
        logic signed [31:0] m21;
        logic signed [31:0] m22;
    } t_mat;

    typedef struct packed {
        logic signed [31:0] r00;
        logic signed [31:0] r01;
        logic signed [31:0] r02;
        logic signed [31:0] r10;
        logic signed [31:0] r11;
        logic signed [31:0] r12;
        logic signed [31:0] r20;
        logic signed [31:0] r21;
        logic signed [31:0] r22;
        logic               converged;
        logic [3:0]         rounds_used;
        logic               singular;
    } t_res;

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_res;

    // round to nearest, ties away from zero
    function automatic logic signed [ACC_W-1:0] rnd_shr(
        input logic signed [ACC_W-1:0] v, input int unsigned sh);
        logic [ACC_W-1:0] mag;
        logic [ACC_W-1:0] res;
        mag = v[ACC_W-1] ? $unsigned(-v) : $unsigned(v);
        res = (mag + ({{(ACC_W-1){1'b0}}, 1'b1} << (sh - 1))) >> sh;
        return v[ACC_W-1] ? -$signed(res) : $signed(res);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = {{(ACC_W-31){1'b0}}, {31{1'b1}}};
        lo = {{(ACC_W-31){1'b1}}, {31{1'b0}}};
        if (v > hi) return 32'sh7fffffff;
        if (v < lo) return 32'sh80000000;
        return v[31:0];
    endfunction

    // element index of (row + di, col + dj) mod 3
    function automatic logic [3:0] rot_idx(input logic [3:0] e,
                                           input logic [1:0] di, input logic [1:0] dj);
        logic [1:0] row;
        logic [1:0] col;
        logic [2:0] rr;
        logic [2:0] cc;
        row = (e >= 4'd6) ? 2'd2 : ((e >= 4'd3) ? 2'd1 : 2'd0);
        col = 2'(e - 4'(row) * 4'd3);
        rr  = 3'(row) + 3'(di);
        cc  = 3'(col) + 3'(dj);
        if (rr >= 3'd3) rr = rr - 3'd3;
        if (cc >= 3'd3) cc = cc - 3'd3;
        return 4'(rr) * 4'd3 + 4'(cc);
    endfunction

endpackage
`default_nettype wire

FILE: design/pd_stream.sv
// ----------------------------------------------------------------------------
// pd_stream
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
`default_nettype none
interface pd_stream #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: design/pd_mac.sv
// ----------------------------------------------------------------------------
// pd_mac
// Shared signed multiplier with accumulator.
// ----------------------------------------------------------------------------
`default_nettype none
module pd_mac (
    input  wire logic                          i_clk,
    input  wire pd_pkg::t_mac_op               i_op,
    input  wire logic signed [32:0]            i_a,
    input  wire logic signed [32:0]            i_b,
    output logic signed [pd_pkg::ACC_W-1:0]    o_acc
);
    import pd_pkg::*;

    logic signed [65:0]      prod;
    logic signed [ACC_W-1:0] prod_x;
    logic signed [ACC_W-1:0] r_acc;
    logic signed [ACC_W-1:0] n_acc;

    assign prod   = i_a * i_b;
    assign prod_x = ACC_W'(prod);

    always_comb begin
        unique case (i_op)
            MAC_LOAD: n_acc = prod_x;
            MAC_ADD:  n_acc = r_acc + prod_x;
            MAC_SUB:  n_acc = r_acc - prod_x;
            default:  n_acc = r_acc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
endmodule
`default_nettype wire

FILE: design/pd_div.sv
// ----------------------------------------------------------------------------
// pd_div
// Restoring divider, one quotient bit per cycle, rounded and overflow-flagged.
// ----------------------------------------------------------------------------
`default_nettype none
module pd_div #(
    parameter int W     = 70,
    parameter int DEN_W = 37
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [W-1:0]     i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output pd_pkg::t_div_res      o_res
);
    import pd_pkg::*;

    logic [W-1:0]     den_x;
    logic [W-1:0]     n_sum;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_dsh;
    logic [QUO_W-1:0] r_quo;
    logic [5:0]       r_cnt;
    logic             r_busy;
    logic             r_done;
    logic             r_ovf;
    logic             ge;

    assign den_x = W'(i_den);
    assign n_sum = i_num + (den_x >> 1);
    assign ge    = r_rem >= r_dsh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem <= n_sum;
                r_dsh <= den_x << (QUO_W - 1);
                r_quo <= '0;
                r_cnt <= 6'(QUO_W);
                if (n_sum >= (den_x << QUO_W)) begin
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else begin
                    r_ovf  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (ge) r_rem <= r_rem - r_dsh;
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_dsh <= r_dsh >> 1;
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quo  = r_quo;
endmodule
`default_nettype wire

FILE: design/polar_decomposition_3x3_core.sv
// ----------------------------------------------------------------------------
// polar_decomposition_3x3_core
// Newton polar iteration of a 3x3 Q4.28 matrix on one shared MAC and divider.
// ----------------------------------------------------------------------------
//  channel   dir   handshake      word
//  i_in      in    valid/ready    t_mat: m00..m22
//  o_out     out   valid/ready    t_res: r00..r22, converged, rounds_used, singular
//  i_cfg_*   in    write enable   max_iterations (0), tolerance (1)
//
//  Per round: cofactors, then the determinant, then nine divisions on the bit-serial
//  divider, then the change norm; the divider takes the largest share of each round.
//  Ready only while idle; a finished word waits in the output register.
//  Reset is synchronous, active low, and restores the register defaults.
`default_nettype none
module polar_decomposition_3x3_core #(
    parameter int FRAC_BITS = pd_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    pd_stream.sink           i_in,
    pd_stream.source         o_out,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [30:0] i_cfg_data
);
    import pd_pkg::*;

    localparam int DMAG_W = 65 - FRAC_BITS;
    localparam int DIV_W  = DMAG_W + 33;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_TOL   = 4'd1;
    localparam logic [3:0] S_COF_A = 4'd2;
    localparam logic [3:0] S_COF_B = 4'd3;
    localparam logic [3:0] S_COF_W = 4'd4;
    localparam logic [3:0] S_DET_A = 4'd5;
    localparam logic [3:0] S_DET_W = 4'd6;
    localparam logic [3:0] S_DIV_S = 4'd7;
    localparam logic [3:0] S_DIV_W = 4'd8;
    localparam logic [3:0] S_CHG_A = 4'd9;
    localparam logic [3:0] S_CHG_D = 4'd10;
    localparam logic [3:0] S_FIN   = 4'd11;

    logic [3:0]  r_state;
    logic [3:0]  r_idx;
    logic [3:0]  r_iter;
    logic [3:0]  r_rounds;
    logic [3:0]  r_maxit;
    logic [30:0] r_tol;
    logic [61:0] r_tol2;
    logic        r_big;
    logic        r_conv;
    logic        r_sing;
    logic        r_out_valid;
    t_res        r_out;

    logic signed [31:0]      r_m  [9];
    logic signed [31:0]      r_c  [9];
    logic signed [31:0]      r_nx [9];
    logic signed [ACC_W-1:0] r_det;

    t_mac_op                 mac_op;
    logic signed [32:0]      mac_a;
    logic signed [32:0]      mac_b;
    logic signed [ACC_W-1:0] acc;

    logic                    div_start;
    logic [DIV_W-1:0]        div_num;
    logic [DMAG_W-1:0]       det_mag;
    t_div_res                div_res;

    logic signed [ACC_W-1:0] det_n;
    logic [ACC_W-1:0]        det_abs;
    logic [31:0]             c_mag;
    logic                    neg;
    logic signed [31:0]      inv_el;
    logic signed [32:0]      sum_el;
    logic signed [31:0]      nx_el;
    logic signed [32:0]      diff;
    logic [32:0]             dm;
    logic                    dm_big;

    pd_mac u_mac (
        .i_clk (i_clk),
        .i_op  (mac_op),
        .i_a   (mac_a),
        .i_b   (mac_b),
        .o_acc (acc)
    );

    pd_div #(.W(DIV_W), .DEN_W(DMAG_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (det_mag),
        .o_res   (div_res)
    );

    assign det_n   = r_det + rnd_shr(acc, FRAC_BITS);
    assign det_abs = r_det[ACC_W-1] ? $unsigned(-r_det) : $unsigned(r_det);
    assign det_mag = det_abs[DMAG_W-1:0];
    assign c_mag   = r_c[r_idx][31] ? $unsigned(-r_c[r_idx]) : $unsigned(r_c[r_idx]);
    assign div_num = DIV_W'(c_mag) << FRAC_BITS;
    assign neg     = r_c[r_idx][31] ^ r_det[ACC_W-1];

    always_comb begin
        if (div_res.ovf) begin
            inv_el = neg ? 32'sh80000000 : 32'sh7fffffff;
        end else if (neg) begin
            inv_el = (div_res.quo > 32'h80000000) ? 32'sh80000000 : -$signed(div_res.quo);
        end else begin
            inv_el = (div_res.quo > 32'h7fffffff) ? 32'sh7fffffff : $signed(div_res.quo);
        end
    end

    assign sum_el = 33'(inv_el) + 33'(r_m[r_idx]);
    assign nx_el  = sat32(rnd_shr(ACC_W'(sum_el), 1));
    assign diff   = 33'(r_nx[r_idx]) - 33'(r_m[r_idx]);
    assign dm     = diff[32] ? $unsigned(-diff) : $unsigned(diff);
    assign dm_big = dm >= 33'h080000000;

    always_comb begin
        mac_op    = MAC_HOLD;
        mac_a     = '0;
        mac_b     = '0;
        div_start = 1'b0;
        unique case (r_state)
            S_TOL: begin
                mac_op = MAC_LOAD;
                mac_a  = $signed({2'b00, r_tol});
                mac_b  = $signed({2'b00, r_tol});
            end
            S_COF_A: begin
                mac_op = MAC_LOAD;
                mac_a  = 33'(r_m[rot_idx(r_idx, 2'd1, 2'd1)]);
                mac_b  = 33'(r_m[rot_idx(r_idx, 2'd2, 2'd2)]);
            end
            S_COF_B: begin
                mac_op = MAC_SUB;
                mac_a  = 33'(r_m[rot_idx(r_idx, 2'd1, 2'd2)]);
                mac_b  = 33'(r_m[rot_idx(r_idx, 2'd2, 2'd1)]);
            end
            S_DET_A: begin
                mac_op = MAC_LOAD;
                mac_a  = 33'(r_m[r_idx]);
                mac_b  = 33'(r_c[r_idx]);
            end
            S_DIV_S: div_start = 1'b1;
            S_CHG_A: begin
                mac_op = (r_idx == 4'd0) ? MAC_LOAD : MAC_ADD;
                mac_a  = dm_big ? 33'sd0 : $signed(dm);
                mac_b  = dm_big ? 33'sd0 : $signed(dm);
            end
            default: mac_op = MAC_HOLD;
        endcase
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_maxit     <= MAX_IT_RST;
            r_tol       <= TOL_RST;
            r_idx       <= '0;
            r_iter      <= '0;
            r_rounds    <= '0;
            r_big       <= 1'b0;
            r_conv      <= 1'b0;
            r_sing      <= 1'b0;
        end else begin
            if (o_out.valid && o_out.ready && (r_state != S_FIN)) r_out_valid <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_IT: r_maxit <= i_cfg_data[3:0];
                    CFG_TOL:    r_tol   <= i_cfg_data;
                    default:    r_tol   <= r_tol;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_m[0] <= i_in.data.m00;
                        r_m[1] <= i_in.data.m01;
                        r_m[2] <= i_in.data.m02;
                        r_m[3] <= i_in.data.m10;
                        r_m[4] <= i_in.data.m11;
                        r_m[5] <= i_in.data.m12;
                        r_m[6] <= i_in.data.m20;
                        r_m[7] <= i_in.data.m21;
                        r_m[8] <= i_in.data.m22;
                        r_iter   <= '0;
                        r_rounds <= '0;
                        r_conv   <= 1'b0;
                        r_sing   <= 1'b0;
                        r_state  <= (r_maxit == 4'd0) ? S_FIN : S_TOL;
                    end
                end
                S_TOL: begin
                    r_idx   <= '0;
                    r_state <= S_COF_A;
                end
                S_COF_A: begin
                    if (r_idx == 4'd0 && r_iter == 4'd0) r_tol2 <= acc[61:0];
                    r_state <= S_COF_B;
                end
                S_COF_B: r_state <= S_COF_W;
                S_COF_W: begin
                    r_c[r_idx] <= sat32(rnd_shr(acc, FRAC_BITS));
                    if (r_idx == 4'd8) begin
                        r_idx   <= '0;
                        r_det   <= '0;
                        r_state <= S_DET_A;
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_COF_A;
                    end
                end
                S_DET_A: r_state <= S_DET_W;
                S_DET_W: begin
                    r_det <= det_n;
                    if (r_idx == 4'd2) begin
                        r_idx <= '0;
                        if (det_n == '0) begin
                            r_sing  <= 1'b1;
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_DIV_S;
                        end
                    end else begin
                        r_idx   <= r_idx + 4'd1;
                        r_state <= S_DET_A;
                    end
                end
                S_DIV_S: r_state <= S_DIV_W;
                S_DIV_W: begin
                    if (div_res.done) begin
                        r_nx[r_idx] <= nx_el;
                        if (r_idx == 4'd8) begin
                            r_idx   <= '0;
                            r_big   <= 1'b0;
                            r_state <= S_CHG_A;
                        end else begin
                            r_idx   <= r_idx + 4'd1;
                            r_state <= S_DIV_S;
                        end
                    end
                end
                S_CHG_A: begin
                    if (dm_big) r_big <= 1'b1;
                    if (r_idx == 4'd8) begin
                        r_state <= S_CHG_D;
                    end else begin
                        r_idx <= r_idx + 4'd1;
                    end
                end
                S_CHG_D: begin
                    r_idx <= '0;
                    if (!r_big && (acc < $signed(ACC_W'(r_tol2)))) begin
                        r_conv  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        for (int k = 0; k < 9; k++) r_m[k] <= r_nx[k];
                        r_rounds <= r_rounds + 4'd1;
                        r_iter   <= r_iter + 4'd1;
                        r_state  <= (5'(r_iter) + 5'd1 >= 5'(r_maxit)) ? S_FIN : S_COF_A;
                    end
                end
                S_FIN: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out.r00         <= r_m[0];
                        r_out.r01         <= r_m[1];
                        r_out.r02         <= r_m[2];
                        r_out.r10         <= r_m[3];
                        r_out.r11         <= r_m[4];
                        r_out.r12         <= r_m[5];
                        r_out.r20         <= r_m[6];
                        r_out.r21         <= r_m[7];
                        r_out.r22         <= r_m[8];
                        r_out.converged   <= r_conv;
                        r_out.rounds_used <= r_rounds;
                        r_out.singular    <= r_sing;
                        r_out_valid       <= 1'b1;
                        r_state           <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: design/pd_checker.sv
// ----------------------------------------------------------------------------
// pd_checker
// Port-level checks on the polar decomposition core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "polar_decomposition_3x3_core_assert.svh"
module pd_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic i_in_ready,
    input wire logic i_out_valid,
    input wire logic i_out_ready,
    input wire logic i_converged,
    input wire logic i_singular
);
    `PD_ASSERT_CLK(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid)
    `PD_ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, i_in_valid && i_in_ready |=> !i_in_ready)
    `PD_ASSERT_CLK(a_flags_exclusive, i_clk, i_rst_n, !(i_out_valid && i_converged && i_singular))
endmodule

bind polar_decomposition_3x3_core pd_checker u_pd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_converged (o_out.data.converged),
    .i_singular  (o_out.data.singular)
);
`default_nettype wire

FILE: dv/polar_decomposition_3x3_core_tb.sv
// ----------------------------------------------------------------------------
// polar_decomposition_3x3_core_tb
// Checks the Newton polar core against a bit-exact fixed-point predictor.
// Directed and random matrices are sent over several register settings.
// Both channels idle at random, and one phase applies long output
// back-pressure. Every result word is compared field by field, in order.
// ----------------------------------------------------------------------------
`default_nettype none
module polar_decomposition_3x3_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pd_pkg::*;

    localparam int FB       = FRAC_BITS_DEF;
    localparam int WDOG_LIM = 60000;
    localparam logic signed [79:0] S_MAX = 80'sd2147483647;
    localparam logic signed [79:0] S_MIN = -80'sd2147483648;
    localparam logic signed [31:0] ONE   = 32'sh10000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [30:0] cfg_data;

    pd_stream #(.T(t_mat)) in_if ();
    pd_stream #(.T(t_res)) out_if ();

    polar_decomposition_3x3_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #2 i_clk = ~i_clk;

    logic [3:0]  pred_max_it;
    logic [30:0] pred_tol;
    t_res        expected_q[$];
    int          n_err;
    bit          calm;
    bit          hold_go;
    bit          hold_done;
    int          rx_gap;
    int          rx_hold;
    int          quiet_cycles;

    function automatic logic signed [79:0] rnd_sh(logic signed [79:0] v, int sh);
        logic [79:0] mg;
        mg = v < 0 ? 80'(-v) : 80'(v);
        mg = (mg + (80'd1 << (sh - 1))) >> sh;
        return v < 0 ? -$signed(mg) : $signed(mg);
    endfunction

    function automatic logic signed [79:0] sat_32(logic signed [79:0] v);
        if (v > S_MAX) return S_MAX;
        if (v < S_MIN) return S_MIN;
        return v;
    endfunction

    function automatic t_res polar_predict(t_mat m);
        logic [287:0]       flat;
        logic signed [79:0] r[3][3];
        logic signed [79:0] c[3][3];
        logic signed [79:0] nx[3][3];
        logic signed [79:0] d;
        logic signed [79:0] det;
        logic signed [79:0] it;
        logic [79:0]        dmag;
        logic [79:0]        num;
        logic [79:0]        q;
        logic [79:0]        dm;
        logic [79:0]        sum;
        logic [79:0]        tol2;
        logic               big;
        logic               conv;
        logic               sing;
        logic               neg;
        int                 rounds;
        t_res               res;
        flat   = m;
        conv   = 1'b0;
        sing   = 1'b0;
        rounds = 0;
        tol2   = 80'(pred_tol) * 80'(pred_tol);
        for (int k = 0; k < 9; k++)
            r[k / 3][k % 3] = 80'($signed(flat[287 - 32 * k -: 32]));
        for (int itn = 0; itn < int'(pred_max_it); itn++) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    d = r[(i + 1) % 3][(j + 1) % 3] * r[(i + 2) % 3][(j + 2) % 3]
                      - r[(i + 1) % 3][(j + 2) % 3] * r[(i + 2) % 3][(j + 1) % 3];
                    c[i][j] = sat_32(rnd_sh(d, FB));
                end
            det = 0;
            for (int j = 0; j < 3; j++)
                det = det + rnd_sh(r[0][j] * c[0][j], FB);
            if (det == 0) begin
                sing = 1'b1;
                break;
            end
            dmag = det < 0 ? 80'(-det) : 80'(det);
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    num = (c[i][j] < 0 ? 80'(-c[i][j]) : 80'(c[i][j])) << FB;
                    q   = (num + dmag / 2) / dmag;
                    neg = (c[i][j] < 0) != (det < 0);
                    if (neg) it = q > 80'h80000000 ? S_MIN : -$signed(q);
                    else     it = q > 80'h7fffffff ? S_MAX : $signed(q);
                    nx[i][j] = sat_32(rnd_sh(r[i][j] + it, 1));
                end
            big = 1'b0;
            sum = 0;
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++) begin
                    d  = nx[i][j] - r[i][j];
                    dm = d < 0 ? 80'(-d) : 80'(d);
                    if (dm >= 80'h80000000) big = 1'b1;
                    else begin
                        sum = sum + dm * dm;
                        if (sum > 80'hffff_ffff_ffff_ffff) sum = 80'hffff_ffff_ffff_ffff;
                    end
                end
            if (!big && sum < tol2) begin
                conv = 1'b1;
                break;
            end
            r = nx;
            rounds++;
        end
        res = {r[0][0][31:0], r[0][1][31:0], r[0][2][31:0],
               r[1][0][31:0], r[1][1][31:0], r[1][2][31:0],
               r[2][0][31:0], r[2][1][31:0], r[2][2][31:0],
               conv, 4'(rounds), sing};
        return res;
    endfunction

    function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            n_err++;
        end
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_res e;
        t_res a;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            a = out_if.data;
            if (expected_q.size() == 0) begin
                $error("result word with none expected");
                n_err++;
            end else begin
                e = expected_q.pop_front();
                check_field("r00", e.r00, a.r00);
                check_field("r01", e.r01, a.r01);
                check_field("r02", e.r02, a.r02);
                check_field("r10", e.r10, a.r10);
                check_field("r11", e.r11, a.r11);
                check_field("r12", e.r12, a.r12);
                check_field("r20", e.r20, a.r20);
                check_field("r21", e.r21, a.r21);
                check_field("r22", e.r22, a.r22);
                check_field("converged", 32'(e.converged), 32'(a.converged));
                check_field("rounds_used", 32'(e.rounds_used), 32'(a.rounds_used));
                check_field("singular", 32'(e.singular), 32'(a.singular));
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (hold_go && !hold_done) begin
            hold_done <= 1'b1;
            rx_hold <= 4000;
            out_if.ready <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            out_if.ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap <= rx_gap - 1;
            out_if.ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_gap <= $urandom_range(0, 8);
            out_if.ready <= 1'b0;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIM) begin
            $display("polar_decomposition_3x3_core verification failed");
            $finish;
        end
    end

    task automatic send_matrix(t_mat m, bit no_gap = 1'b0);
        int gap;
        in_if.data  <= m;
        in_if.valid <= 1'b1;
        do @(posedge i_clk); while (!in_if.ready);
        expected_q.insert(expected_q.size(), polar_predict(m));
        @(negedge i_clk);
        if (!calm && !no_gap && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [30:0] val);
        drain();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_MAX_IT) pred_max_it = val[3:0];
        else                   pred_tol    = val;
    endtask

    function automatic t_mat diag_mat(logic signed [31:0] a, logic signed [31:0] b,
                                      logic signed [31:0] c);
        t_mat m;
        m = '0;
        m.m00 = a;
        m.m11 = b;
        m.m22 = c;
        return m;
    endfunction

    function automatic t_mat rand_mat();
        t_mat m;
        m = {$urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, $urandom};
        return m;
    endfunction

    // scaled near-orthonormal matrix with random perturbation
    function automatic t_mat near_orth();
        logic [287:0]       f;
        logic signed [31:0] v;
        int                 sh;
        sh = $urandom_range(1, 4);
        for (int k = 0; k < 9; k++) begin
            v = $signed($urandom) >>> ($urandom_range(3, 12));
            if (k % 4 == 0) v = v + ($urandom_range(0, 1) ? ONE : -ONE) + (ONE >>> sh);
            f[287 - 32 * k -: 32] = v;
        end
        return t_mat'(f);
    endfunction

    function automatic t_mat singular_mat();
        t_mat m;
        m = near_orth();
        case ($urandom_range(0, 2))
            0: begin m.m20 = m.m00; m.m21 = m.m01; m.m22 = m.m02; end
            1: begin m.m01 = '0; m.m11 = '0; m.m21 = '0; end
            default: begin
                m = diag_mat(32'(int'($urandom_range(1, 64))), ONE, ONE);
            end
        endcase
        return m;
    endfunction

    function automatic t_mat pick_mat();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6) return near_orth();
        if (sel < 8) return rand_mat();
        return singular_mat();
    endfunction

    task automatic test_directed();
        t_mat m;
        send_matrix(diag_mat(ONE, ONE, ONE));
        send_matrix(diag_mat(-ONE, -ONE, -ONE));
        send_matrix('0);
        send_matrix({9{32'sh7fffffff}});
        send_matrix({9{32'sh80000000}});
        send_matrix(diag_mat(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        send_matrix(diag_mat(32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_matrix(diag_mat(ONE <<< 1, ONE >>> 1, ONE));
        send_matrix(diag_mat(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag_mat(32'sh7fffffff, 32'sh80000000, ONE));
        m = '0;
        m.m01 = ONE; m.m12 = ONE; m.m20 = ONE;
        send_matrix(m);
        m = diag_mat(ONE, ONE, ONE);
        m.m01 = ONE >>> 3; m.m10 = -(ONE >>> 4); m.m21 = ONE >>> 5;
        send_matrix(m);
        send_matrix(singular_mat());
        repeat (6) send_matrix(rand_mat());
    endtask

    task automatic test_reg_extremes();
        write_reg(CFG_MAX_IT, 31'd0);
        repeat (4) send_matrix(pick_mat());
        write_reg(CFG_MAX_IT, 31'd15);
        write_reg(CFG_TOL, 31'd0);
        repeat (4) send_matrix(near_orth());
        send_matrix(singular_mat());
        write_reg(CFG_TOL, 31'h7fffffff);
        repeat (4) send_matrix(pick_mat());
        write_reg(CFG_MAX_IT, 31'd1);
        write_reg(CFG_TOL, 31'd268);
        repeat (4) send_matrix(pick_mat());
    endtask

    task automatic test_random(int n);
        for (int p = 0; p < 6; p++) begin
            write_reg(CFG_MAX_IT, 31'($urandom_range(0, 3) == 0 ?
                                     $urandom_range(0, 15) : $urandom_range(1, 6)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_TOL, 31'($urandom));
                1: write_reg(CFG_TOL, 31'($urandom_range(0, 4096)));
                default: write_reg(CFG_TOL, 31'($urandom_range(1, 1 << 20)));
            endcase
            repeat (n / 6) send_matrix(pick_mat());
        end
    endtask

    task automatic test_backpressure();
        write_reg(CFG_MAX_IT, 31'd4);
        write_reg(CFG_TOL, 31'd268);
        @(negedge i_clk);
        hold_go = 1'b1;
        repeat (6) send_matrix(pick_mat(), 1'b1);
    endtask

    task automatic test_pause();
        repeat (5) send_matrix(pick_mat());
        drain();
        repeat (5) send_matrix(pick_mat());
    endtask

    task automatic test_calm_tail();
        write_reg(CFG_MAX_IT, 31'd10);
        calm = 1'b1;
        repeat (30) send_matrix(pick_mat());
    endtask

    initial begin
        calm         = 1'b0;
        hold_go      = 1'b0;
        pred_max_it  = MAX_IT_RST;
        pred_tol     = TOL_RST;
        i_rst_n      = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = 1'b0;
        cfg_data     = '0;
        in_if.valid  = 1'b0;
        in_if.data   = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_reg_extremes();
        test_random(300);
        test_backpressure();
        test_pause();
        test_calm_tail();
        drain();
        repeat (50) @(posedge i_clk);
        if (n_err == 0 && expected_q.size() == 0) begin
            $display("polar_decomposition_3x3_core verification clean");
        end else begin
            if (expected_q.size() != 0) $error("%0d results missing", expected_q.size());
            $display("polar_decomposition_3x3_core verification failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
